/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // default geometry
  localparam int unsigned OrdersDef    = 11;
  localparam int unsigned TopBlocksDef = 32;
  localparam int unsigned MinBlockDef  = 128;

  // fixed field widths
  localparam int unsigned HdrW   = 7;
  localparam int unsigned BytesW = 18;
  localparam int unsigned OffW   = 22;
  localparam int unsigned OrdW   = 4;
  localparam int unsigned TallyW = 16;
  localparam int unsigned TagW   = 6;

  localparam logic [HdrW-1:0] HdrReset = 7'd32;

  // tag layout: head flag, free flag, order
  localparam int unsigned TagHeadBit = 5;
  localparam int unsigned TagFreeBit = 4;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StZero    = 3'd1,
    StBig     = 3'd2,
    StNoSpace = 3'd3,
    StIgnored = 3'd4
  } bba_status_e;

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SAllocSize,
    SAllocRead,
    SAllocCheck,
    SAllocSplit,
    SFreeCheck,
    SFreeTagRead,
    SFreeTag,
    SFreeLoop,
    SFreeBuddy,
    SFreeClrSelf,
    SFreeFinish,
    SDone
  } bba_state_e;

  function automatic logic [TagW-1:0] make_tag(input logic is_free,
                                               input logic [OrdW-1:0] ord);
    make_tag = {1'b1, is_free, ord};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator; block tags held per minimum-size unit in one RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  request  | in_valid_i / in_ready_o | mode_i, request_bytes_i, free_offset_i
//  result   | out_valid_o/out_ready_i | status_o, payload_offset_o,
//           |                         | block_order_o, total_blocks_o
//  config   | cfg_we_i                | cfg_wdata_i (header bytes)
//
// One request at a time. Allocate: size check, then a tag read and check per
// block walked head to head in address order through the tag RAM, and a tag
// write per split. Free: offset check, tag read and check, then a buddy read,
// check and clear per merge, and a final write; the single-port tag RAM walk
// sets the pace. After reset a clearing pass over TOP_BLOCKS << (ORDERS-1)
// units sets up the tag RAM, holding off requests; config writes are taken.
// A result waiting in the output register does not block the next request.
`default_nettype none

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned ORDERS     = OrdersDef,
  parameter int unsigned TOP_BLOCKS = TopBlocksDef,
  parameter int unsigned MIN_BLOCK  = MinBlockDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              mode_i,
  input  wire logic [BytesW-1:0] request_bytes_i,
  input  wire logic [OffW-1:0]   free_offset_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             status_o,
  output logic [OffW-1:0]        payload_offset_o,
  output logic [OrdW-1:0]        block_order_o,
  output logic [TallyW-1:0]      total_blocks_o,
  input  wire logic              cfg_we_i,
  input  wire logic [HdrW-1:0]   cfg_wdata_i
);

  localparam int unsigned TopOrder  = ORDERS - 1;
  localparam int unsigned HeapUnits = TOP_BLOCKS << TopOrder;
  localparam int unsigned UW        = $clog2(HeapUnits);
  localparam int unsigned UA        = UW + 1;
  localparam int unsigned MinSh     = $clog2(MIN_BLOCK);
  localparam logic [31:0] TopBytes  = 32'(MIN_BLOCK) << TopOrder;
  localparam logic [UA-1:0] HeapEnd = UA'(HeapUnits);

  bba_state_e state_q, state_d;

  logic [BytesW-1:0] bytes_q;
  logic [OffW-1:0]   off_q;
  logic [HdrW-1:0]   hdr_q;
  logic [TallyW-1:0] tally_q, tally_d;
  logic [OrdW-1:0]   k_q, k_d, ord_q, ord_d;
  logic              found_q, found_d;
  logic [UA-1:0]     u_q, u_d, b_q, b_d, clr_q, clr_d;
  bba_status_e       res_st_q, res_st_d;
  logic [OffW-1:0]   res_off_q, res_off_d;
  logic [OrdW-1:0]   res_ord_q, res_ord_d;
  logic              load_out;

  // tag ram
  logic [TagW-1:0] tag_mem [HeapUnits];
  logic            mem_we;
  logic [UW-1:0]   mem_waddr, mem_raddr;
  logic [TagW-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= tag_mem[mem_raddr];
  end

  // combinational helpers
  logic [31:0]     need32, off32, addr32, blk_off32;
  logic [OrdW-1:0] k_calc, t_ord;
  logic            t_head, t_free, cand;
  logic [UA-1:0]   next_u, buddy;

  always_comb begin
    need32 = 32'(bytes_q) + 32'(hdr_q);
    k_calc = OrdW'(TopOrder);
    for (int i = TopOrder; i >= 0; i--) begin
      if ((32'(MIN_BLOCK) << i) >= need32) begin
        k_calc = OrdW'(i);
      end
    end
    off32  = 32'(off_q);
    addr32 = off32 - 32'(hdr_q);
    t_ord  = rdata_q[OrdW-1:0];
    t_head = rdata_q[TagHeadBit];
    t_free = rdata_q[TagFreeBit];
    cand   = t_head && t_free && (t_ord >= k_q) && (!found_q || (t_ord < ord_q));
    next_u = u_q + (UA'(1) << t_ord);
    buddy  = u_q ^ (UA'(1) << ord_q);
    blk_off32 = (32'(u_q) << MinSh) + 32'(hdr_q);
  end

  always_comb begin
    state_d   = state_q;
    tally_d   = tally_q;
    k_d       = k_q;
    ord_d     = ord_q;
    found_d   = found_q;
    u_d       = u_q;
    b_d       = b_q;
    clr_d     = clr_q;
    res_st_d  = res_st_q;
    res_off_d = res_off_q;
    res_ord_d = res_ord_q;
    mem_we    = 1'b0;
    mem_waddr = u_q[UW-1:0];
    mem_wdata = '0;
    mem_raddr = u_q[UW-1:0];
    load_out  = 1'b0;

    unique case (state_q)
      SClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[UW-1:0];
        mem_wdata = (clr_q[TopOrder-1:0] == '0) ? make_tag(1'b1, OrdW'(TopOrder)) : '0;
        if (clr_q == HeapEnd - UA'(1)) begin
          state_d = SIdle;
        end else begin
          clr_d = clr_q + UA'(1);
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          state_d = mode_i ? SFreeCheck : SAllocSize;
        end
      end
      SAllocSize: begin
        res_off_d = '0;
        res_ord_d = '0;
        priority if (bytes_q == '0) begin
          res_st_d = StZero;
          state_d  = SDone;
        end else if (need32 > TopBytes) begin
          res_st_d = StBig;
          state_d  = SDone;
        end else begin
          k_d     = k_calc;
          u_d     = '0;
          found_d = 1'b0;
          state_d = SAllocRead;
        end
      end
      SAllocRead: begin
        state_d = SAllocCheck;
      end
      SAllocCheck: begin
        // walk head to head; keep the smallest fitting order, first address
        if (cand) begin
          b_d     = u_q;
          ord_d   = t_ord;
          found_d = 1'b1;
        end
        if (cand && (t_ord == k_q)) begin
          u_d     = u_q;
          state_d = SAllocSplit;
        end else if (next_u >= HeapEnd) begin
          if (cand || found_q) begin
            u_d     = cand ? u_q : b_q;
            state_d = SAllocSplit;
          end else begin
            res_st_d  = StNoSpace;
            res_off_d = '0;
            res_ord_d = '0;
            state_d   = SDone;
          end
        end else begin
          u_d     = next_u;
          state_d = SAllocRead;
        end
      end
      SAllocSplit: begin
        mem_we = 1'b1;
        if (ord_q > k_q) begin
          mem_waddr = UW'(u_q + (UA'(1) << (ord_q - OrdW'(1))));
          mem_wdata = make_tag(1'b1, ord_q - OrdW'(1));
          ord_d     = ord_q - OrdW'(1);
          tally_d   = tally_q + TallyW'(1);
        end else begin
          mem_wdata = make_tag(1'b0, k_q);
          res_st_d  = StOk;
          res_off_d = blk_off32[OffW-1:0];
          res_ord_d = k_q;
          state_d   = SDone;
        end
      end
      SFreeCheck: begin
        if ((off32 < 32'(hdr_q)) || (addr32[MinSh-1:0] != '0) ||
            ((addr32 >> MinSh) >= 32'(HeapUnits))) begin
          res_st_d  = StIgnored;
          res_off_d = '0;
          res_ord_d = '0;
          state_d   = SDone;
        end else begin
          u_d     = UA'(addr32 >> MinSh);
          state_d = SFreeTagRead;
        end
      end
      SFreeTagRead: begin
        state_d = SFreeTag;
      end
      SFreeTag: begin
        if (!t_head || t_free) begin
          res_st_d  = StIgnored;
          res_off_d = '0;
          res_ord_d = '0;
          state_d   = SDone;
        end else begin
          ord_d   = t_ord;
          state_d = SFreeLoop;
        end
      end
      SFreeLoop: begin
        mem_raddr = buddy[UW-1:0];
        b_d       = buddy;
        if ((ord_q >= OrdW'(TopOrder)) || (buddy >= HeapEnd)) begin
          state_d = SFreeFinish;
        end else begin
          state_d = SFreeBuddy;
        end
      end
      SFreeBuddy: begin
        if (t_head && t_free && (t_ord == ord_q)) begin
          mem_we    = 1'b1;
          mem_waddr = b_q[UW-1:0];
          state_d   = SFreeClrSelf;
        end else begin
          state_d = SFreeFinish;
        end
      end
      SFreeClrSelf: begin
        mem_we  = 1'b1;
        tally_d = tally_q - TallyW'(1);
        if (b_q < u_q) begin
          u_d = b_q;
        end
        ord_d   = ord_q + OrdW'(1);
        state_d = SFreeLoop;
      end
      SFreeFinish: begin
        mem_we    = 1'b1;
        mem_wdata = make_tag(1'b1, ord_q);
        res_st_d  = StOk;
        res_off_d = blk_off32[OffW-1:0];
        res_ord_d = ord_q;
        state_d   = SDone;
      end
      SDone: begin
        if (!out_valid_o || out_ready_i) begin
          load_out = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      hdr_q    <= HdrReset;
      tally_q  <= TallyW'(TOP_BLOCKS);
      k_q      <= '0;
      ord_q    <= '0;
      found_q  <= 1'b0;
      u_q      <= '0;
      b_q      <= '0;
      clr_q    <= '0;
      res_st_q <= StOk;
    end else begin
      state_q  <= state_d;
      tally_q  <= tally_d;
      k_q      <= k_d;
      ord_q    <= ord_d;
      found_q  <= found_d;
      u_q      <= u_d;
      b_q      <= b_d;
      clr_q    <= clr_d;
      res_st_q <= res_st_d;
      if (cfg_we_i) begin
        hdr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_off_q <= res_off_d;
    res_ord_q <= res_ord_d;
    if (in_valid_i && in_ready_o) begin
      bytes_q <= request_bytes_i;
      off_q   <= free_offset_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o         <= res_st_q;
      payload_offset_o <= res_off_q;
      block_order_o    <= res_ord_q;
      total_blocks_o   <= tally_q;
    end
  end

  assign in_ready_o = (state_q == SIdle);

endmodule

`default_nettype wire

/* rtl/core/bba_checker.sv */
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [2:0]        status_o,
  input wire logic [OffW-1:0]   payload_offset_o,
  input wire logic [OrdW-1:0]   block_order_o,
  input wire logic [TallyW-1:0] total_blocks_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(payload_offset_o) && $stable(total_blocks_o))
    else $error("result changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> (payload_offset_o == '0) &&
    (block_order_o == '0))
    else $error("failed result carries data");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StOk) || (status_o == StZero) ||
    (status_o == StBig) || (status_o == StNoSpace) || (status_o == StIgnored))
    else $error("unknown status");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .payload_offset_o (payload_offset_o),
  .block_order_o    (block_order_o),
  .total_blocks_o   (total_blocks_o)
);

`default_nettype wire
